/* rtl/hts_pkg.sv */
// Shared types and codes for the heightfield triangle sampler.
`default_nettype none

package hts_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_METERS_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_PIXELS_PER_METER = 2'd1;
  localparam logic [1:0] CFG_MAX_ELEVATION    = 2'd2;

  localparam logic [15:0] RST_METERS_PER_PIXEL = 16'd256;
  localparam logic [15:0] RST_PIXELS_PER_METER = 16'd256;
  localparam logic [15:0] RST_MAX_ELEVATION    = 16'd8192;

  localparam logic [15:0] NORMAL_ONE = 16'd16384;

  typedef logic [30:0] hts_mag_t;

  typedef struct packed {
    logic [23:0] height;
    logic        zero;
    logic        neg_x;
    logic        neg_z;
  } hts_carry_t;

endpackage

`default_nettype wire

/* rtl/heightfield_triangle_sample.sv */
// Heightfield triangle sampler: banked heightmap, interpolated height and face normal.
// A query's result is driven with done once it leaves the divider pipeline.
// One transaction is accepted every cycle; busy stays low, loads give no result.
// Each cycle the heightmap's four parity banks are each read once; a load writes one bank.
// Reset clears the valid bits and the configuration registers; heightmap contents
// are undefined until loaded and no clearing pass runs.
`default_nettype none

module heightfield_triangle_sample
  import hts_pkg::*;
#(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int TEXEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [7:0]         texel_col,
  input  wire logic [7:0]         texel_row,
  input  wire logic [15:0]        texel_value,
  input  wire logic signed [23:0] query_x,
  input  wire logic signed [23:0] query_z,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    done,
  output logic [23:0]             height,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z
);

  localparam int TW         = (TEXEL_BITS < 16) ? TEXEL_BITS : 16;
  localparam int HW         = TW + 16;
  localparam int PRW        = HW + 17;
  localparam int PW         = HW + 19;
  localparam int BANK_W     = (MAP_WIDTH + 1) / 2;
  localparam int BANK_H     = (MAP_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_W * BANK_H;
  localparam int BA         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int SQ_STEPS   = 32;
  localparam int DV_STEPS   = 15;

  // configuration
  logic [15:0] meters_per_pixel, pixels_per_meter, max_elevation;

  always_ff @(posedge clk) begin
    if (rst) begin
      meters_per_pixel <= RST_METERS_PER_PIXEL;
      pixels_per_meter <= RST_PIXELS_PER_METER;
      max_elevation    <= RST_MAX_ELEVATION;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_METERS_PER_PIXEL: meters_per_pixel <= cfg_data;
        CFG_PIXELS_PER_METER: pixels_per_meter <= cfg_data;
        CFG_MAX_ELEVATION:    max_elevation <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: capture
  logic               s1_v, s1_op;
  logic [7:0]         s1_col, s1_row;
  logic [15:0]        s1_val;
  logic signed [23:0] s1_qx, s1_qz;

  // stage 2: scale to pixels
  logic               s2_v, s2_op;
  logic [7:0]         s2_col, s2_row;
  logic [15:0]        s2_val;
  logic signed [39:0] s2_vx, s2_vz;

  // stage 3: addresses
  logic               s3_v, s3_op, s3_wr_ok;
  logic [1:0]         s3_wr_bank;
  logic [TW-1:0]      s3_wr_data;
  logic [BA-1:0]      s3_addr [4];
  logic [1:0]         s3_tbank [3];
  logic [2:0]         s3_tin;
  logic [15:0]        s3_fx, s3_fz;
  logic               s3_sel;

  // stage 4: bank read
  logic               s4_v;
  logic [TW-1:0]      s4_rd [4];
  logic [1:0]         s4_tbank [3];
  logic [2:0]         s4_tin;
  logic [15:0]        s4_fx, s4_fz;
  logic               s4_sel;

  // stage 5: texels and weights
  logic               s5_v, s5_sel;
  logic [TW-1:0]      s5_t [3];
  logic [16:0]        s5_w [3];

  // stage 6: scaled heights
  logic               s6_v, s6_sel;
  logic [HW-1:0]      s6_h [3];
  logic [16:0]        s6_w [3];

  // stage 7: weighted products and differences
  logic               s7_v;
  logic [PRW-1:0]     s7_p [3];
  logic [23:0]        s7_abs0, s7_abs2;
  logic               s7_neg0, s7_neg2;

  // stage 8: height and raw normal magnitudes
  logic               s8_v;
  hts_carry_t         s8_c;
  logic [47:0]        s8_mag [3];

  // stage 9: largest magnitude
  logic               s9_v;
  hts_carry_t         s9_c;
  logic [47:0]        s9_mag [3];
  logic [47:0]        s9_big;

  // stage 10: normalize shift
  logic               s10_v;
  hts_carry_t         s10_c;
  logic [47:0]        s10_mag [3];
  logic               s10_right;
  logic [5:0]         s10_amt;

  // stage 11: normalized magnitudes
  logic               s11_v;
  hts_carry_t         s11_c;
  hts_mag_t           s11_nm [3];

  // stage 12: squares
  logic               s12_v;
  hts_carry_t         s12_c;
  hts_mag_t           s12_nm [3];
  logic [61:0]        s12_sq [3];

  // square root pipeline, index 0 holds the sum of squares
  logic               sq_v    [SQ_STEPS+1];
  hts_carry_t         sq_c    [SQ_STEPS+1];
  hts_mag_t           sq_nm   [SQ_STEPS+1][3];
  logic [63:0]        sq_s    [SQ_STEPS+1];
  logic [34:0]        sq_rem  [SQ_STEPS+1];
  logic [31:0]        sq_root [SQ_STEPS+1];

  // divider pipeline, index 0 holds rounded numerators
  logic               dv_v    [DV_STEPS+1];
  hts_carry_t         dv_c    [DV_STEPS+1];
  logic [31:0]        dv_d    [DV_STEPS+1];
  logic [46:0]        dv_rem  [DV_STEPS+1][3];
  logic [14:0]        dv_q    [DV_STEPS+1][3];

  logic [TW-1:0]      bank_mem [4][BANK_DEPTH];

  function automatic logic inside_map(input logic [24:0] cx, input logic [24:0] cz);
    logic ok;
    ok = !cx[24] && !cz[24] && (cx[23:0] < 24'(MAP_WIDTH)) && (cz[23:0] < 24'(MAP_HEIGHT));
    return ok;
  endfunction

  function automatic logic [BA-1:0] bank_addr(input logic [11:0] hx, input logic [11:0] hz);
    logic [31:0] a;
    a = 32'(hz) * 32'(BANK_W) + 32'(hx);
    return a[BA-1:0];
  endfunction

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      s5_v  <= 1'b0;
      s6_v  <= 1'b0;
      s7_v  <= 1'b0;
      s8_v  <= 1'b0;
      s9_v  <= 1'b0;
      s10_v <= 1'b0;
      s11_v <= 1'b0;
      s12_v <= 1'b0;
      for (int i = 0; i <= SQ_STEPS; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i <= DV_STEPS; i++) dv_v[i] <= 1'b0;
      done  <= 1'b0;
    end else begin
      s1_v  <= start && !busy;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v && (s3_op == OP_QUERY);
      s5_v  <= s4_v;
      s6_v  <= s5_v;
      s7_v  <= s6_v;
      s8_v  <= s7_v;
      s9_v  <= s8_v;
      s10_v <= s9_v;
      s11_v <= s10_v;
      s12_v <= s11_v;
      sq_v[0] <= s12_v;
      for (int i = 0; i < SQ_STEPS; i++) sq_v[i+1] <= sq_v[i];
      dv_v[0] <= sq_v[SQ_STEPS];
      for (int i = 0; i < DV_STEPS; i++) dv_v[i+1] <= dv_v[i];
      done  <= dv_v[DV_STEPS];
    end
  end

  // stages 1 and 2
  always_ff @(posedge clk) begin
    s1_op  <= operation;
    s1_col <= texel_col;
    s1_row <= texel_row;
    s1_val <= texel_value;
    s1_qx  <= query_x;
    s1_qz  <= query_z;
    s2_op  <= s1_op;
    s2_col <= s1_col;
    s2_row <= s1_row;
    s2_val <= s1_val;
    s2_vx  <= s1_qx * $signed({1'b0, pixels_per_meter});
    s2_vz  <= s1_qz * $signed({1'b0, pixels_per_meter});
  end

  // stage 3
  logic [24:0]   px0, pz0, px1, pz1;
  logic [24:0]   tcx [3];
  logic [24:0]   tcz [3];
  logic [BA-1:0] taddr [3];
  logic [BA-1:0] addr_next [4];
  logic [BA-1:0] ld_addr;
  logic          sel_next;

  always_comb begin
    px0 = {s2_vx[39], s2_vx[39:16]};
    pz0 = {s2_vz[39], s2_vz[39:16]};
    px1 = px0 + 25'd1;
    pz1 = pz0 + 25'd1;
    sel_next = s2_vx[15:0] > s2_vz[15:0];
    tcx[0] = px0;
    tcz[0] = pz0;
    tcx[1] = px1;
    tcz[1] = pz1;
    tcx[2] = sel_next ? px1 : px0;
    tcz[2] = sel_next ? pz0 : pz1;
    for (int k = 0; k < 3; k++) taddr[k] = bank_addr(tcx[k][12:1], tcz[k][12:1]);
    ld_addr = bank_addr({5'd0, s2_col[7:1]}, {5'd0, s2_row[7:1]});
    for (int j = 0; j < 4; j++) begin
      addr_next[j] = ld_addr;
      if (s2_op == OP_QUERY) begin
        for (int k = 0; k < 3; k++) begin
          if ({tcz[k][0], tcx[k][0]} == 2'(j)) addr_next[j] = taddr[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_wr_ok <= 1'b0;
    end else begin
      s3_wr_ok <= s2_v && (s2_op == OP_LOAD) && (32'(s2_col) < 32'(MAP_WIDTH))
                  && (32'(s2_row) < 32'(MAP_HEIGHT));
    end
  end

  always_ff @(posedge clk) begin
    s3_op      <= s2_op;
    s3_wr_bank <= {s2_row[0], s2_col[0]};
    s3_wr_data <= s2_val[TW-1:0];
    for (int j = 0; j < 4; j++) s3_addr[j] <= addr_next[j];
    for (int k = 0; k < 3; k++) begin
      s3_tbank[k] <= {tcz[k][0], tcx[k][0]};
      s3_tin[k]   <= inside_map(tcx[k], tcz[k]);
    end
    s3_fx  <= s2_vx[15:0];
    s3_fz  <= s2_vz[15:0];
    s3_sel <= sel_next;
  end

  // stage 4: banks
  for (genvar j = 0; j < 4; j++) begin : g_bank
    always_ff @(posedge clk) begin
      if (s3_wr_ok && (s3_wr_bank == 2'(j))) bank_mem[j][s3_addr[j]] <= s3_wr_data;
      s4_rd[j] <= bank_mem[j][s3_addr[j]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) s4_tbank[k] <= s3_tbank[k];
    s4_tin <= s3_tin;
    s4_fx  <= s3_fx;
    s4_fz  <= s3_fz;
    s4_sel <= s3_sel;
  end

  // stages 5 to 8
  logic signed [24:0] ha, hb, hc, d0, d2;
  logic [PW-1:0]      hsum;

  always_comb begin
    ha = $signed({1'b0, 24'(s6_h[0] >> (TEXEL_BITS - 8))});
    hb = $signed({1'b0, 24'(s6_h[1] >> (TEXEL_BITS - 8))});
    hc = $signed({1'b0, 24'(s6_h[2] >> (TEXEL_BITS - 8))});
    d0 = s6_sel ? (ha - hc) : (hc - hb);
    d2 = s6_sel ? (hc - hb) : (ha - hc);
    hsum = PW'(s7_p[0]) + PW'(s7_p[1]) + PW'(s7_p[2]) + (PW'(1) << (TEXEL_BITS + 15));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) s5_t[k] <= s4_tin[k] ? s4_rd[s4_tbank[k]] : '0;
    s5_sel <= s4_sel;
    if (s4_sel) begin
      s5_w[0] <= 17'h10000 - 17'(s4_fx);
      s5_w[1] <= 17'(s4_fz);
      s5_w[2] <= 17'(s4_fx) - 17'(s4_fz);
    end else begin
      s5_w[0] <= 17'h10000 - 17'(s4_fz);
      s5_w[1] <= 17'(s4_fx);
      s5_w[2] <= 17'(s4_fz) - 17'(s4_fx);
    end

    for (int k = 0; k < 3; k++) begin
      s6_h[k] <= HW'(s5_t[k]) * HW'(max_elevation);
      s6_w[k] <= s5_w[k];
    end
    s6_sel <= s5_sel;

    for (int k = 0; k < 3; k++) s7_p[k] <= PRW'(s6_h[k]) * PRW'(s6_w[k]);
    s7_neg0 <= d0[24];
    s7_neg2 <= d2[24];
    s7_abs0 <= d0[24] ? 24'(-d0) : d0[23:0];
    s7_abs2 <= d2[24] ? 24'(-d2) : d2[23:0];

    s8_c.height <= 24'(hsum >> (TEXEL_BITS + 16));
    s8_c.zero   <= (meters_per_pixel == 16'd0);
    s8_c.neg_x  <= s7_neg0;
    s8_c.neg_z  <= s7_neg2;
    s8_mag[0]   <= {24'd0, meters_per_pixel, 8'd0} * {24'd0, s7_abs0};
    s8_mag[1]   <= {24'd0, meters_per_pixel, 8'd0} * {24'd0, meters_per_pixel, 8'd0};
    s8_mag[2]   <= {24'd0, meters_per_pixel, 8'd0} * {24'd0, s7_abs2};
  end

  // stages 9 to 12: normalize so the largest magnitude has its top bit at 30, then square
  logic [47:0] big01;
  logic [5:0]  msb_pos;
  logic [47:0] shifted [3];

  always_comb begin
    big01 = (s8_mag[1] > s8_mag[0]) ? s8_mag[1] : s8_mag[0];
    msb_pos = '0;
    for (int i = 0; i < 48; i++) begin
      if (s9_big[i]) msb_pos = 6'(i);
    end
    for (int k = 0; k < 3; k++) begin
      shifted[k] = s10_right ? (s10_mag[k] >> s10_amt) : (s10_mag[k] << s10_amt);
    end
  end

  always_ff @(posedge clk) begin
    s9_c   <= s8_c;
    s9_big <= (s8_mag[2] > big01) ? s8_mag[2] : big01;
    for (int k = 0; k < 3; k++) s9_mag[k] <= s8_mag[k];

    s10_c     <= s9_c;
    s10_right <= msb_pos > 6'd30;
    s10_amt   <= (msb_pos > 6'd30) ? (msb_pos - 6'd30) : (6'd30 - msb_pos);
    for (int k = 0; k < 3; k++) s10_mag[k] <= s9_mag[k];

    s11_c <= s10_c;
    for (int k = 0; k < 3; k++) s11_nm[k] <= shifted[k][30:0];

    s12_c <= s11_c;
    for (int k = 0; k < 3; k++) begin
      s12_nm[k] <= s11_nm[k];
      s12_sq[k] <= {31'd0, s11_nm[k]} * {31'd0, s11_nm[k]};
    end

    sq_c[0]    <= s12_c;
    for (int k = 0; k < 3; k++) sq_nm[0][k] <= s12_nm[k];
    sq_s[0]    <= 64'(s12_sq[0]) + 64'(s12_sq[1]) + 64'(s12_sq[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    logic [34:0] rem_sh, trial;
    always_comb begin
      rem_sh = {sq_rem[i][32:0], sq_s[i][63-2*i -: 2]};
      trial  = {1'b0, sq_root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      sq_c[i+1] <= sq_c[i];
      sq_s[i+1] <= sq_s[i];
      for (int k = 0; k < 3; k++) sq_nm[i+1][k] <= sq_nm[i][k];
      if (rem_sh >= trial) begin
        sq_rem[i+1]  <= rem_sh - trial;
        sq_root[i+1] <= {sq_root[i][30:0], 1'b1};
      end else begin
        sq_rem[i+1]  <= rem_sh;
        sq_root[i+1] <= {sq_root[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_c[0] <= sq_c[SQ_STEPS];
    dv_d[0] <= sq_root[SQ_STEPS];
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] <= {2'b0, sq_nm[SQ_STEPS][k], 14'd0} + 47'(sq_root[SQ_STEPS] >> 1);
      dv_q[0][k]   <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < DV_STEPS; i++) begin : g_div
    logic [46:0] dsh;
    assign dsh = {15'd0, dv_d[i]} << (DV_STEPS - 1 - i);
    always_ff @(posedge clk) begin
      dv_c[i+1] <= dv_c[i];
      dv_d[i+1] <= dv_d[i];
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[i][k] >= dsh) begin
          dv_rem[i+1][k] <= dv_rem[i][k] - dsh;
          dv_q[i+1][k]   <= dv_q[i][k] | (15'd1 << (DV_STEPS - 1 - i));
        end else begin
          dv_rem[i+1][k] <= dv_rem[i][k];
          dv_q[i+1][k]   <= dv_q[i][k];
        end
      end
    end
  end

  // output
  logic [15:0] qx, qy, qz;

  always_comb begin
    qx = {1'b0, dv_q[DV_STEPS][0]};
    qy = {1'b0, dv_q[DV_STEPS][1]};
    qz = {1'b0, dv_q[DV_STEPS][2]};
  end

  always_ff @(posedge clk) begin
    height <= dv_c[DV_STEPS].height;
    if (dv_c[DV_STEPS].zero) begin
      normal_x <= '0;
      normal_y <= NORMAL_ONE;
      normal_z <= '0;
    end else begin
      normal_x <= dv_c[DV_STEPS].neg_x ? (16'd0 - qx) : qx;
      normal_y <= qy;
      normal_z <= dv_c[DV_STEPS].neg_z ? (16'd0 - qz) : qz;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    dv_v[0] && !dv_c[0].zero |-> dv_d[0][31:30] != 2'b00)
    else $error("square root below normalized range");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !normal_y[15] && height <= 24'd65536)
    else $error("height or up component out of range");

  assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384
             && normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
    else $error("normal component exceeds unit length");

  assert property (@(posedge clk) disable iff (rst)
    s3_wr_ok |-> s3_v && s3_op == OP_LOAD)
    else $error("bank write without a load transaction");

endmodule

`default_nettype wire
